FILE: rtl/lagr_pkg.sv
// ----------------------------------------------------------------------------
// lagr_pkg : shared types and constants of the Lagrange interpolation unit
// Sequencer states, status codes and fixed-point widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lagr_pkg;

  // Q16.16 format
  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  // Dividend of the ratio divide: 33-bit magnitude shifted by the fraction
  localparam int unsigned DvdW  = 49;
  localparam int unsigned DivW  = 33;
  localparam int unsigned CntW  = 6;

  // Command codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CMP,
    S_TERM_RD,
    S_TERM_LD,
    S_PAIR_SEL,
    S_PAIR_RD,
    S_DIV_INIT,
    S_DIV,
    S_RATIO,
    S_MUL,
    S_SCALE,
    S_FINAL,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/lagr_ram.sv
// ----------------------------------------------------------------------------
// lagr_ram : generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lagr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/lagrange_interpolation_unit.sv
// ----------------------------------------------------------------------------
// lagrange_interpolation_unit : Lagrange polynomial interpolation, Q16.16
// Stores sample points and evaluates the interpolating polynomial at a query
// with one shared restoring divider and one multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | request   | in_valid_i/in_ready_o | command, first_point, point_x,
//          |           |                       | point_y, query_x
//  out     | result    | out_valid_o/out_ready_i | value, status
//
//  A load is answered in the cycle after it is taken. An evaluate of n points
//  compares up to n*(n-1)/2 node pairs, then forms n*(n-1) ratios, each by a
//  49-step bit-serial divide.
//  Reset clears the point count and the sequencer; the stores need no clear.
//  in_ready_o is high only when idle and the output register is free or
//  being emptied; a stalled result holds the sequencer in its last state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lagrange_interpolation_unit #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic        first_point_i,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] query_x_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o,
  output logic [1:0]       status_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = lagr_pkg::DataW + AW + 1;
  localparam int unsigned DW = lagr_pkg::DataW;
  localparam int unsigned PW = 2 * DW;

  lagr_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [DW-1:0] qx_q, qx_d;
  logic [DW-1:0] p_q, p_d;
  logic [DW-1:0] r_q, r_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          sat_q, sat_d;
  logic          neg_q, neg_d;
  logic [lagr_pkg::DvdW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [lagr_pkg::DivW-1:0] div_q, div_d;
  logic [lagr_pkg::DivW:0]   rem_q, rem_d;
  logic [lagr_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] res_val_q, res_val_d;
  logic [1:0]    res_st_q, res_st_d;

  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_val_q, out_val_d;
  logic [1:0]    out_st_q, out_st_d;

  // Point stores: two copies of x for reads at i and j
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] xa_rd, xb_rd, y_rd;

  lagr_ram #(.Width(DW), .Depth(MAX_POINTS)) u_xa_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(point_x_i),
    .raddr_i(i_q[AW-1:0]), .rdata_o(xa_rd)
  );
  lagr_ram #(.Width(DW), .Depth(MAX_POINTS)) u_xb_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(point_x_i),
    .raddr_i(j_q[AW-1:0]), .rdata_o(xb_rd)
  );
  lagr_ram #(.Width(DW), .Depth(MAX_POINTS)) u_y_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(point_y_i),
    .raddr_i(i_q[AW-1:0]), .rdata_o(y_rd)
  );

  // Datapath helpers
  logic                      out_free;
  logic                      accept;
  logic [lagr_pkg::DivW-1:0] d_s, e_s, d_abs, e_abs;
  logic [lagr_pkg::DivW:0]   rem_sh;
  logic [lagr_pkg::DivW+1:0] rem_diff;
  logic [PW-1:0]             prod_adj;
  logic [PW-lagr_pkg::FracW-1:0] prod_sc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == lagr_pkg::S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign d_s   = {qx_q[DW-1], qx_q} - {xb_rd[DW-1], xb_rd};
  assign e_s   = {xa_rd[DW-1], xa_rd} - {xb_rd[DW-1], xb_rd};
  assign d_abs = d_s[lagr_pkg::DivW-1] ? -d_s : d_s;
  assign e_abs = e_s[lagr_pkg::DivW-1] ? -e_s : e_s;

  assign rem_sh   = {rem_q[lagr_pkg::DivW-1:0], dvd_q[lagr_pkg::DvdW-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, div_q};

  // Truncate toward zero on the fraction shift
  assign prod_adj = prod_q + (prod_q[PW-1] ? PW'(16'hFFFF) : PW'(0));
  assign prod_sc  = prod_adj[PW-1:lagr_pkg::FracW];

  assign we    = accept && (command_i == lagr_pkg::CmdLoad) &&
                 (first_point_i || (count_q < CW'(MAX_POINTS)));
  assign waddr = first_point_i ? AW'(0) : count_q[AW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    qx_d        = qx_q;
    p_d         = p_q;
    r_d         = r_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;

    unique case (state_q)
      lagr_pkg::S_IDLE: begin
        if (accept) begin
          if (command_i == lagr_pkg::CmdLoad) begin
            out_valid_d = 1'b1;
            out_val_d   = '0;
            if (first_point_i) begin
              count_d  = CW'(1);
              out_st_d = lagr_pkg::ST_OK;
            end else if (count_q < CW'(MAX_POINTS)) begin
              count_d  = count_q + CW'(1);
              out_st_d = lagr_pkg::ST_OK;
            end else begin
              out_st_d = lagr_pkg::ST_FULL;
            end
          end else begin
            qx_d  = query_x_i;
            n_d   = count_q;
            i_d   = '0;
            j_d   = CW'(1);
            sum_d = '0;
            sat_d = 1'b0;
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              out_val_d   = '0;
              out_st_d    = lagr_pkg::ST_OK;
            end else if (count_q == CW'(1)) begin
              j_d     = '0;
              state_d = lagr_pkg::S_TERM_RD;
            end else begin
              state_d = lagr_pkg::S_DUP_RD;
            end
          end
        end
      end

      // Repeated node search over pairs i < j
      lagr_pkg::S_DUP_RD: state_d = lagr_pkg::S_DUP_CMP;

      lagr_pkg::S_DUP_CMP: begin
        if (xa_rd == xb_rd) begin
          res_val_d = '0;
          res_st_d  = lagr_pkg::ST_DUP;
          state_d   = lagr_pkg::S_DONE;
        end else if ((j_q + CW'(1)) == n_q) begin
          if (({1'b0, i_q} + (CW+1)'(2)) >= {1'b0, n_q}) begin
            i_d     = '0;
            j_d     = '0;
            state_d = lagr_pkg::S_TERM_RD;
          end else begin
            i_d     = i_q + CW'(1);
            j_d     = i_q + CW'(2);
            state_d = lagr_pkg::S_DUP_RD;
          end
        end else begin
          j_d     = j_q + CW'(1);
          state_d = lagr_pkg::S_DUP_RD;
        end
      end

      // Start of term i: product starts at y_i
      lagr_pkg::S_TERM_RD: state_d = lagr_pkg::S_TERM_LD;

      lagr_pkg::S_TERM_LD: begin
        p_d     = y_rd;
        j_d     = '0;
        state_d = lagr_pkg::S_PAIR_SEL;
      end

      lagr_pkg::S_PAIR_SEL: begin
        if (j_q == n_q) begin
          sum_d = sum_q + {{(SW-DW){p_q[DW-1]}}, p_q};
          if ((i_q + CW'(1)) == n_q) begin
            state_d = lagr_pkg::S_FINAL;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = lagr_pkg::S_TERM_RD;
          end
        end else if (j_q == i_q) begin
          j_d = j_q + CW'(1);
        end else begin
          state_d = lagr_pkg::S_PAIR_RD;
        end
      end

      lagr_pkg::S_PAIR_RD: state_d = lagr_pkg::S_DIV_INIT;

      // Ratio (q - x_j) * 2^16 / (x_i - x_j) on magnitudes
      lagr_pkg::S_DIV_INIT: begin
        dvd_d   = {d_abs, lagr_pkg::FracW'(0)};
        div_d   = e_abs;
        neg_d   = d_s[lagr_pkg::DivW-1] ^ e_s[lagr_pkg::DivW-1];
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = lagr_pkg::CntW'(lagr_pkg::DvdW);
        state_d = lagr_pkg::S_DIV;
      end

      lagr_pkg::S_DIV: begin
        dvd_d = {dvd_q[lagr_pkg::DvdW-2:0], 1'b0};
        if (!rem_diff[lagr_pkg::DivW+1]) begin
          rem_d = rem_diff[lagr_pkg::DivW:0];
          quo_d = {quo_q[lagr_pkg::DvdW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[lagr_pkg::DvdW-2:0], 1'b0};
        end
        cnt_d = cnt_q - lagr_pkg::CntW'(1);
        if (cnt_q == lagr_pkg::CntW'(1)) begin
          state_d = lagr_pkg::S_RATIO;
        end
      end

      // Sign and clamp of the ratio
      lagr_pkg::S_RATIO: begin
        if (!neg_q && (|quo_q[lagr_pkg::DvdW-1:DW-1])) begin
          r_d   = {1'b0, {(DW-1){1'b1}}};
          sat_d = 1'b1;
        end else if (neg_q && ((|quo_q[lagr_pkg::DvdW-1:DW]) ||
                               (quo_q[DW-1] && (|quo_q[DW-2:0])))) begin
          r_d   = {1'b1, {(DW-1){1'b0}}};
          sat_d = 1'b1;
        end else begin
          r_d = neg_q ? -quo_q[DW-1:0] : quo_q[DW-1:0];
        end
        state_d = lagr_pkg::S_MUL;
      end

      lagr_pkg::S_MUL: begin
        prod_d  = $signed(p_q) * $signed(r_q);
        state_d = lagr_pkg::S_SCALE;
      end

      // Fraction shift and clamp of the running product
      lagr_pkg::S_SCALE: begin
        if ((&prod_sc[PW-lagr_pkg::FracW-1:DW-1]) ||
            !(|prod_sc[PW-lagr_pkg::FracW-1:DW-1])) begin
          p_d = prod_sc[DW-1:0];
        end else begin
          p_d   = prod_sc[PW-lagr_pkg::FracW-1] ? {1'b1, {(DW-1){1'b0}}}
                                                : {1'b0, {(DW-1){1'b1}}};
          sat_d = 1'b1;
        end
        j_d     = j_q + CW'(1);
        state_d = lagr_pkg::S_PAIR_SEL;
      end

      // Clamp of the total
      lagr_pkg::S_FINAL: begin
        if ((&sum_q[SW-1:DW-1]) || !(|sum_q[SW-1:DW-1])) begin
          res_val_d = sum_q[DW-1:0];
          res_st_d  = sat_q ? lagr_pkg::ST_SAT : lagr_pkg::ST_OK;
        end else begin
          res_val_d = sum_q[SW-1] ? {1'b1, {(DW-1){1'b0}}}
                                  : {1'b0, {(DW-1){1'b1}}};
          res_st_d  = lagr_pkg::ST_SAT;
        end
        state_d = lagr_pkg::S_DONE;
      end

      lagr_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_st_d    = res_st_q;
          state_d     = lagr_pkg::S_IDLE;
        end
      end

      default: state_d = lagr_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lagr_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    i_q       <= i_d;
    j_q       <= j_d;
    qx_q      <= qx_d;
    p_q       <= p_d;
    r_q       <= r_d;
    prod_q    <= prod_d;
    sum_q     <= sum_d;
    sat_q     <= sat_d;
    neg_q     <= neg_d;
    dvd_q     <= dvd_d;
    quo_q     <= quo_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire

FILE: rtl/lagr_checker.sv
// ----------------------------------------------------------------------------
// lagr_checker : port-level checks of the Lagrange interpolation unit
// Watches the handshakes and result codes seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lagr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        command_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] value_o,
  input wire logic [1:0]  status_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("result changed while stalled");

  // No new request while the output register is full and stalled
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken with output stalled");

  // A load answers in the next cycle with value zero
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == lagr_pkg::CmdLoad)
      |=> out_valid_o && (value_o == '0))
    else $error("load result missing or non-zero");

  // Repeated node and full store always carry value zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == lagr_pkg::ST_DUP) || (status_o == lagr_pkg::ST_FULL))
      |-> (value_o == '0))
    else $error("error result with non-zero value");

endmodule

bind lagrange_interpolation_unit lagr_checker u_lagr_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i,
  .out_valid_o, .out_ready_i, .value_o, .status_o
);

`default_nettype wire
